/* hw/rtl/sfd_pkg.sv */
// Package for the sensor frame deframer.
// Holds the frame phase type, result kind codes, register indexes and the result record.
// No dependencies.
package sfd_pkg;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BROKEN   = 2'd2,
        KIND_OVERSIZE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        HDR_BUS_ID  = 3'd0,
        HDR_MSG_ID  = 3'd1,
        HDR_LEN     = 3'd2,
        HDR_LEN_HI  = 3'd3,
        HDR_LEN_LO  = 3'd4
    } hdr_pos_t;

    localparam logic [1:0] CFG_PREAMBLE    = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;

    localparam logic [7:0]  EXT_LEN_MARK        = 8'hFF;
    localparam logic [7:0]  PREAMBLE_RESET      = 8'd250;
    localparam logic [15:0] MAX_PAYLOAD_RESET   = 16'd2048;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_id;
        logic [7:0]  payload_byte;
        logic [15:0] frame_length;
        logic        last;
    } result_t;

endpackage

/* hw/rtl/sfd_core.sv */
// Frame parser of the sensor frame deframer: phase, header, length and checksum state.
// Produces at most one result per accepted byte, combinationally from the current state.
// Depends on sfd_pkg.
module sfd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          preamble_byte,
    input  logic [15:0]         max_payload,
    output logic                res_valid,
    output sfd_pkg::result_t    res
);

    sfd_pkg::phase_t   phase_reg, phase_next;
    sfd_pkg::hdr_pos_t header_pos_reg, header_pos_next;
    logic [15:0]       payload_len_reg, payload_len_next;
    logic [15:0]       payload_count_reg, payload_count_next;
    logic [7:0]        frame_id_reg, frame_id_next;
    logic [7:0]        running_sum_reg, running_sum_next;

    logic [7:0]        sum_add;
    logic [15:0]       count_inc;
    logic [15:0]       len_cand;
    sfd_pkg::phase_t   len_phase;

    assign sum_add   = running_sum_reg + rx_byte;
    assign count_inc = payload_count_reg + 16'd1;

    always_comb
    begin
        len_cand = {8'd0, rx_byte};
        if (header_pos_reg != sfd_pkg::HDR_LEN)
        begin
            len_cand = {payload_len_reg[15:8], rx_byte};
        end
        if ((len_cand != 16'd0) && (len_cand <= max_payload))
        begin
            len_phase = sfd_pkg::PH_DATA;
        end
        else
        begin
            len_phase = sfd_pkg::PH_CHECK;
        end
    end

    always_comb
    begin
        phase_next         = phase_reg;
        header_pos_next    = header_pos_reg;
        payload_len_next   = payload_len_reg;
        payload_count_next = payload_count_reg;
        frame_id_next      = frame_id_reg;
        running_sum_next   = running_sum_reg;
        if (in_fire)
        begin
            case (phase_reg)
                sfd_pkg::PH_HUNT:
                begin
                    if (rx_byte == preamble_byte)
                    begin
                        running_sum_next = 8'd0;
                        header_pos_next  = sfd_pkg::HDR_BUS_ID;
                        phase_next       = sfd_pkg::PH_HEADER;
                    end
                end
                sfd_pkg::PH_HEADER:
                begin
                    running_sum_next = sum_add;
                    case (header_pos_reg)
                        sfd_pkg::HDR_BUS_ID:
                        begin
                            header_pos_next = sfd_pkg::HDR_MSG_ID;
                        end
                        sfd_pkg::HDR_MSG_ID:
                        begin
                            frame_id_next   = rx_byte;
                            header_pos_next = sfd_pkg::HDR_LEN;
                        end
                        sfd_pkg::HDR_LEN:
                        begin
                            if (rx_byte != sfd_pkg::EXT_LEN_MARK)
                            begin
                                payload_len_next   = len_cand;
                                header_pos_next    = sfd_pkg::HDR_BUS_ID;
                                payload_count_next = 16'd0;
                                phase_next         = len_phase;
                            end
                            else
                            begin
                                header_pos_next = sfd_pkg::HDR_LEN_HI;
                            end
                        end
                        sfd_pkg::HDR_LEN_HI:
                        begin
                            payload_len_next = {rx_byte, 8'd0};
                            header_pos_next  = sfd_pkg::HDR_LEN_LO;
                        end
                        default:
                        begin
                            payload_len_next   = len_cand;
                            header_pos_next    = sfd_pkg::HDR_BUS_ID;
                            payload_count_next = 16'd0;
                            phase_next         = len_phase;
                        end
                    endcase
                end
                sfd_pkg::PH_DATA:
                begin
                    running_sum_next   = sum_add;
                    payload_count_next = count_inc;
                    if (count_inc == payload_len_reg)
                    begin
                        phase_next = sfd_pkg::PH_CHECK;
                    end
                end
                default:
                begin
                    running_sum_next = sum_add;
                    phase_next       = sfd_pkg::PH_HUNT;
                    header_pos_next  = sfd_pkg::HDR_BUS_ID;
                end
            endcase
        end
    end

    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = sfd_pkg::KIND_PAYLOAD;
        res.msg_id       = frame_id_reg;
        res.payload_byte = 8'd0;
        res.frame_length = payload_len_reg;
        res.last         = 1'b0;
        case (phase_reg)
            sfd_pkg::PH_DATA:
            begin
                res_valid        = in_fire;
                res.payload_byte = rx_byte;
            end
            sfd_pkg::PH_CHECK:
            begin
                res_valid = in_fire;
                res.last  = 1'b1;
                if (payload_len_reg > max_payload)
                begin
                    res.kind = sfd_pkg::KIND_OVERSIZE;
                end
                else if (sum_add != 8'd0)
                begin
                    res.kind = sfd_pkg::KIND_BROKEN;
                end
                else
                begin
                    res.kind = sfd_pkg::KIND_GOOD;
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= sfd_pkg::PH_HUNT;
            header_pos_reg    <= sfd_pkg::HDR_BUS_ID;
            payload_len_reg   <= 16'd0;
            payload_count_reg <= 16'd0;
            frame_id_reg      <= 8'd0;
            running_sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            header_pos_reg    <= header_pos_next;
            payload_len_reg   <= payload_len_next;
            payload_count_reg <= payload_count_next;
            frame_id_reg      <= frame_id_next;
            running_sum_reg   <= running_sum_next;
        end
    end

`ifndef SYNTHESIS
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_DATA) |-> (payload_count_reg < payload_len_reg))
        else $error("payload count reached the declared length while still in payload");

    a_hunt_header_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == sfd_pkg::PH_HUNT) |-> (header_pos_reg == sfd_pkg::HDR_BUS_ID))
        else $error("header position not cleared while hunting");

    a_sum_cleared_on_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (phase_reg == sfd_pkg::PH_HUNT))
        |=> ((phase_reg == sfd_pkg::PH_HUNT) || (running_sum_reg == 8'd0)))
        else $error("checksum not cleared at the preamble");
`endif

endmodule

/* hw/rtl/sfd_outbuf.sv */
// Two-entry output buffer of the sensor frame deframer: a result register and a skid register.
// Lets the parser take a new beat while a finished result still waits downstream.
// Depends on sfd_pkg.
module sfd_outbuf
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                res_valid,
    input  sfd_pkg::result_t    res,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output sfd_pkg::result_t    out_res
);

    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    sfd_pkg::result_t out_res_reg, out_res_next;
    sfd_pkg::result_t skid_res_reg, skid_res_next;
    logic             out_take;

    assign out_take  = out_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = res_valid;
            if (res_valid)
            begin
                out_res_next = res;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

/* hw/rtl/sensor_frame_deframer.sv */
// Top level of the sensor frame deframer: configuration registers, parser and output buffer.
// Depends on sfd_pkg, sfd_core and sfd_outbuf.
//
// The deframer takes one received byte per cycle while rx_stall is low, and each result
// is registered in the output buffer once its byte is accepted. Every byte is handled
// by a single registered step of the parser, so a new byte may be offered in every cycle;
// a two-entry output buffer holds results while the downstream side stalls, and rx_stall
// rises only when both of its entries are occupied. Preamble and header bytes give no
// result; payload bytes give a payload beat and the checksum byte gives the status beat
// with last set. Configuration writes take effect at the next byte.
module sensor_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        rx_valid,
    output logic        rx_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  msg_id,
    output logic [7:0]  payload_byte,
    output logic [15:0] frame_length,
    output logic        last
);

    logic [7:0]       preamble_byte_reg;
    logic [15:0]      max_payload_reg;
    logic             in_fire;
    logic             res_valid;
    logic             buf_full;
    sfd_pkg::result_t res;
    sfd_pkg::result_t out_res;

    assign rx_stall = buf_full;
    assign in_fire  = rx_valid && !buf_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preamble_byte_reg <= sfd_pkg::PREAMBLE_RESET;
            max_payload_reg   <= sfd_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sfd_pkg::CFG_PREAMBLE)
            begin
                preamble_byte_reg <= cfg_data[7:0];
            end
            else if (cfg_index == sfd_pkg::CFG_MAX_PAYLOAD)
            begin
                max_payload_reg <= cfg_data;
            end
        end
    end

    sfd_core u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_fire       (in_fire),
        .rx_byte       (rx_byte),
        .preamble_byte (preamble_byte_reg),
        .max_payload   (max_payload_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    sfd_outbuf u_outbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign msg_id       = out_res.msg_id;
    assign payload_byte = out_res.payload_byte;
    assign frame_length = out_res.frame_length;
    assign last         = out_res.last;

endmodule

/* verif/sensor_frame_deframer_test.sv */
// Self-checking testbench for sensor_frame_deframer: a directed table of frames, then
// random frames under six register settings, each beat checked by predictor or table.
// Depends on sfd_pkg and the sensor_frame_deframer RTL only.
`timescale 1ns / 1ps

module sensor_frame_deframer_test;

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;
    localparam int BYTES_PER_SETTING = 165;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic [7:0]      b;
        logic            typed;
        sfd_pkg::kind_t  kind;
        logic [7:0]      id;
        logic [15:0]     len;
    } stim_row_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = sfd_pkg::CFG_PREAMBLE;
    logic [15:0] cfg_data = '0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  msg_id;
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        last;

    // Predictor state and its copy of the registers.
    logic [7:0]        pre_reg;
    logic [15:0]       max_reg;
    sfd_pkg::phase_t   fr_phase;
    sfd_pkg::hdr_pos_t fr_hpos;
    logic [15:0]       fr_len;
    logic [15:0]       fr_count;
    logic [7:0]        fr_id;
    logic [7:0]        fr_sum;

    sfd_pkg::result_t  awaited_beats[$];
    stim_row_t         directed_rows[0:26];
    bit                quiet = 1'b0;
    int                mismatches = 0;
    int                payload_beats = 0;
    int                status_beats = 0;
    int                frames_sent = 0;

    sensor_frame_deframer uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .msg_id       (msg_id),
        .payload_byte (payload_byte),
        .frame_length (frame_length),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic stim_row_t plain(input logic [7:0] b);
        stim_row_t r;
        r = '0;
        r.b = b;
        r.kind = sfd_pkg::KIND_PAYLOAD;
        return r;
    endfunction

    function automatic stim_row_t status(input logic [7:0] b, input sfd_pkg::kind_t k,
                                         input logic [7:0] id, input logic [15:0] len);
        stim_row_t r;
        r.b = b;
        r.typed = 1'b1;
        r.kind = k;
        r.id = id;
        r.len = len;
        return r;
    endfunction

    task automatic reset_deframer_model();
        pre_reg = sfd_pkg::PREAMBLE_RESET;
        max_reg = sfd_pkg::MAX_PAYLOAD_RESET;
        fr_phase = sfd_pkg::PH_HUNT;
        fr_hpos = sfd_pkg::HDR_BUS_ID;
        fr_len = '0;
        fr_count = '0;
        fr_id = '0;
        fr_sum = '0;
    endtask

    // Advances the frame parser by one received byte and gives the beat it causes.
    task automatic deframe_byte(input logic [7:0] b, output bit made,
                                output sfd_pkg::result_t beat);
        made = 1'b0;
        beat = '0;
        if (fr_phase == sfd_pkg::PH_HUNT)
        begin
            if (b == pre_reg)
            begin
                fr_sum = '0;
                fr_hpos = sfd_pkg::HDR_BUS_ID;
                fr_phase = sfd_pkg::PH_HEADER;
            end
        end
        else
        begin
            fr_sum = fr_sum + b;
            case (fr_phase)
                sfd_pkg::PH_HEADER:
                begin
                    case (fr_hpos)
                        sfd_pkg::HDR_BUS_ID: fr_hpos = sfd_pkg::HDR_MSG_ID;
                        sfd_pkg::HDR_MSG_ID:
                        begin
                            fr_id = b;
                            fr_hpos = sfd_pkg::HDR_LEN;
                        end
                        sfd_pkg::HDR_LEN:
                        begin
                            if (b != sfd_pkg::EXT_LEN_MARK)
                            begin
                                fr_len = {8'h00, b};
                                fr_hpos = sfd_pkg::HDR_BUS_ID;
                                fr_count = '0;
                                fr_phase = (fr_len != 0 && fr_len <= max_reg)
                                           ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
                            end
                            else
                            begin
                                fr_hpos = sfd_pkg::HDR_LEN_HI;
                            end
                        end
                        sfd_pkg::HDR_LEN_HI:
                        begin
                            fr_len = {b, 8'h00};
                            fr_hpos = sfd_pkg::HDR_LEN_LO;
                        end
                        default:
                        begin
                            fr_len = {fr_len[15:8], b};
                            fr_hpos = sfd_pkg::HDR_BUS_ID;
                            fr_count = '0;
                            fr_phase = (fr_len != 0 && fr_len <= max_reg)
                                       ? sfd_pkg::PH_DATA : sfd_pkg::PH_CHECK;
                        end
                    endcase
                end
                sfd_pkg::PH_DATA:
                begin
                    made = 1'b1;
                    beat.kind = sfd_pkg::KIND_PAYLOAD;
                    beat.msg_id = fr_id;
                    beat.payload_byte = b;
                    beat.frame_length = fr_len;
                    beat.last = 1'b0;
                    fr_count = fr_count + 16'd1;
                    if (fr_count == fr_len)
                        fr_phase = sfd_pkg::PH_CHECK;
                end
                default:
                begin
                    made = 1'b1;
                    if (fr_len > max_reg)
                        beat.kind = sfd_pkg::KIND_OVERSIZE;
                    else if (fr_sum != 0)
                        beat.kind = sfd_pkg::KIND_BROKEN;
                    else
                        beat.kind = sfd_pkg::KIND_GOOD;
                    beat.msg_id = fr_id;
                    beat.payload_byte = '0;
                    beat.frame_length = fr_len;
                    beat.last = 1'b1;
                    fr_phase = sfd_pkg::PH_HUNT;
                    fr_hpos = sfd_pkg::HDR_BUS_ID;
                end
            endcase
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit gaps, input bit typed,
                             input sfd_pkg::result_t typed_beat);
        bit               made;
        sfd_pkg::result_t beat;
        if (gaps && !quiet && $urandom_range(0, 7) == 0)
        begin
            rx_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall)
            @(posedge clk);
        deframe_byte(b, made, beat);
        if (typed)
            awaited_beats.push_back(typed_beat);
        else if (made)
            awaited_beats.push_back(beat);
    endtask

    // Holds the sender back until every awaited beat has come and the parser has settled.
    task automatic drain_beats();
        rx_valid <= 1'b0;
        while (awaited_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        if (idx == sfd_pkg::CFG_PREAMBLE)
            pre_reg = value[7:0];
        else if (idx == sfd_pkg::CFG_MAX_PAYLOAD)
            max_reg = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_frame(output int frame_bytes);
        logic [7:0]  bytes_q[$];
        logic [15:0] len;
        logic [7:0]  sum;
        int          pick;
        bit          gaps;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            len = 16'($urandom_range(0, 12));
        else if (pick < 70)
            len = 16'($urandom_range(13, 40));
        else if (pick < 85 && max_reg <= 40)
            len = max_reg + 16'($urandom_range(0, 1));
        else if (max_reg != 16'hFFFF)
            len = 16'($urandom_range(int'(max_reg) + 1, 65535));
        else
            len = 16'($urandom_range(0, 12));
        bytes_q.push_back(pre_reg);
        bytes_q.push_back(8'($urandom_range(0, 255)));
        bytes_q.push_back(8'($urandom_range(0, 255)));
        if (len < 16'd255 && $urandom_range(0, 2) != 0)
        begin
            bytes_q.push_back(len[7:0]);
        end
        else
        begin
            bytes_q.push_back(sfd_pkg::EXT_LEN_MARK);
            bytes_q.push_back(len[15:8]);
            bytes_q.push_back(len[7:0]);
        end
        if (len != 0 && len <= max_reg)
            for (int i = 0; i < int'(len); i++)
                bytes_q.push_back(($urandom_range(0, 15) == 0) ? pre_reg
                                                               : 8'($urandom_range(0, 255)));
        sum = '0;
        for (int i = 1; i < bytes_q.size(); i++)
            sum = sum + bytes_q[i];
        sum = -sum;
        if ($urandom_range(0, 4) == 0)
            sum = sum + 8'($urandom_range(1, 255));
        bytes_q.push_back(sum);
        if ($urandom_range(0, 19) == 0)
            bytes_q = bytes_q[0:$urandom_range(1, bytes_q.size() - 2)];
        frame_bytes = bytes_q.size();
        repeat ($urandom_range(0, 2))
            bytes_q.push_back(($urandom_range(0, 7) == 0) ? pre_reg : 8'($urandom_range(0, 255)));
        gaps = $urandom_range(0, 9) < 7;
        foreach (bytes_q[i])
            send_byte(bytes_q[i], gaps, 1'b0, '0);
        frames_sent++;
    endtask

    // Downstream stalls in bursts, with calm stretches between them, except in the quiet setting.
    initial
    begin
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        sfd_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (last)
                status_beats++;
            else
                payload_beats++;
            if (awaited_beats.size() == 0)
            begin
                report_mismatch($sformatf("beat with none awaited: kind %0d id %02h",
                                          kind, msg_id));
            end
            else
            begin
                want = awaited_beats.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d", kind, want.kind));
                if (msg_id !== want.msg_id)
                    report_mismatch($sformatf("msg_id %02h, wanted %02h", msg_id, want.msg_id));
                if (payload_byte !== want.payload_byte)
                    report_mismatch($sformatf("payload_byte %02h, wanted %02h",
                                              payload_byte, want.payload_byte));
                if (frame_length !== want.frame_length)
                    report_mismatch($sformatf("frame_length %04h, wanted %04h",
                                              frame_length, want.frame_length));
                if (last !== want.last)
                    report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
            end
        end
    end

    initial
    begin
        sfd_pkg::result_t typed_beat;
        logic [7:0]       pre;
        logic [15:0]      mx;
        int               setting_bytes;
        int               n;

        reset_deframer_model();
        directed_rows = '{
            plain(8'h00),
            // Good frame with an extended length of one.
            plain(8'hFA), plain(8'h00), plain(8'h80), plain(8'hFF), plain(8'h00), plain(8'h01),
            plain(8'h00), status(8'h80, sfd_pkg::KIND_GOOD, 8'h80, 16'h0001),
            // Zero length with a wrong checksum; the next preamble follows at once.
            plain(8'hFA), plain(8'hFF), plain(8'hFF), plain(8'h00),
            status(8'h00, sfd_pkg::KIND_BROKEN, 8'hFF, 16'h0000),
            // Largest length is oversize and skips straight to the checksum byte.
            plain(8'hFA), plain(8'h01), plain(8'h5A), plain(8'hFF), plain(8'hFF), plain(8'hFF),
            status(8'h00, sfd_pkg::KIND_OVERSIZE, 8'h5A, 16'hFFFF),
            // Short good frame whose payload equals the preamble.
            plain(8'hFA), plain(8'h01), plain(8'h10), plain(8'h01), plain(8'hFA),
            status(8'hF4, sfd_pkg::KIND_GOOD, 8'h10, 16'h0001)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            typed_beat = '0;
            typed_beat.kind = directed_rows[i].kind;
            typed_beat.msg_id = directed_rows[i].id;
            typed_beat.frame_length = directed_rows[i].len;
            typed_beat.last = 1'b1;
            send_byte(directed_rows[i].b, 1'b1, directed_rows[i].typed, typed_beat);
        end

        for (int setting = 0; setting < 6; setting++)
        begin
            case (setting)
                0:
                begin
                    pre = 8'h00;
                    mx = 16'hFFFF;
                end
                1:
                begin
                    pre = 8'hFF;
                    mx = 16'h0000;
                end
                2:
                begin
                    pre = 8'($urandom_range(0, 255));
                    mx = 16'd8;
                end
                3:
                begin
                    pre = 8'($urandom_range(0, 255));
                    mx = 16'($urandom_range(0, 40));
                end
                4:
                begin
                    pre = sfd_pkg::PREAMBLE_RESET;
                    mx = sfd_pkg::MAX_PAYLOAD_RESET;
                end
                default:
                begin
                    pre = 8'($urandom_range(0, 255));
                    mx = 16'($urandom_range(1, 20));
                end
            endcase
            drain_beats();
            quiet = (setting == 5);
            write_reg(sfd_pkg::CFG_PREAMBLE, {8'h00, pre});
            write_reg(sfd_pkg::CFG_MAX_PAYLOAD, mx);
            write_reg(setting[0] ? CFG_SPARE_B : CFG_SPARE_A, 16'($urandom_range(0, 65535)));
            setting_bytes = 0;
            while (setting_bytes < BYTES_PER_SETTING)
            begin
                send_frame(n);
                setting_bytes += n;
            end
        end

        drain_beats();
        $display("Sent %0d directed bytes and %0d random frames under six register settings.",
                 $size(directed_rows), frames_sent);
        $display("Checked %0d payload beats and %0d status beats.", payload_beats, status_beats);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_core.sv
hw/rtl/sfd_outbuf.sv
hw/rtl/sensor_frame_deframer.sv
verif/sensor_frame_deframer_test.sv
